// ----- hdl/elpd_pkg.sv -----
// Shared types and constants for the erasure peeling decoder.
`timescale 1ns / 1ps
`default_nettype none

package elpd_pkg;

  // Fixed widths of the item fields.
  localparam int unsigned FIELD_W     = 12;
  localparam int unsigned ROW_INDEX_W = 4;
  localparam int unsigned PASS_W      = 6;

  // Rows addressable by a load word.
  localparam int unsigned INDEX_ROWS = 2 ** ROW_INDEX_W;

  localparam logic [PASS_W-1:0] MAX_PASSES_RESET = 6'd30;

  // Queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [FIELD_W-1:0] word_t;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } back_state_e;

  // One classified word as it waits in the queue.
  typedef struct packed {
    logic                   is_load;
    logic                   load_ok;
    logic [ROW_INDEX_W-1:0] index;
    word_t                  row;
    word_t                  bits;
    word_t                  erased;
  } item_t;

endpackage

`default_nettype wire

// ----- hdl/elpd_front.sv -----
// Front part: accepts input words, classifies them and queues them for the back.
`timescale 1ns / 1ps
`default_nettype none

module elpd_front import elpd_pkg::*; #(
  parameter int unsigned CODE_W = 12,
  parameter int unsigned ROWS   = 9
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output      logic                   in_stall_o,
  input  wire logic                   operation_i,
  input  wire logic [ROW_INDEX_W-1:0] row_index_i,
  input  wire logic [FIELD_W-1:0]     row_bits_i,
  input  wire logic [FIELD_W-1:0]     hard_bits_i,
  input  wire logic [FIELD_W-1:0]     erasure_mask_i,
  output      logic                   item_valid_o,
  output      item_t                  item_o,
  input  wire logic                   item_pop_i
);

  localparam word_t CodeMask = FIELD_W'((64'd1 << CODE_W) - 64'd1);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  item_t             queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  item_t             item_new;
  logic              push;
  logic              pop;
  word_t             erased_in;

  assign in_stall_o   = (count_q == CntW'(QUEUE_DEPTH));
  assign item_valid_o = (count_q != '0);
  assign item_o       = queue_q[rd_ptr_q];

  assign push = in_valid_i && !in_stall_o;
  assign pop  = item_pop_i && item_valid_o;

  // Bits beyond the code length are dropped here, so the back never sees them.
  always_comb begin
    erased_in        = erasure_mask_i & CodeMask;
    item_new.is_load = (op_e'(operation_i) == OP_LOAD);
    item_new.load_ok = (32'(row_index_i) < 32'(ROWS));
    item_new.index   = row_index_i;
    item_new.row     = row_bits_i & CodeMask;
    item_new.bits    = hard_bits_i & CodeMask & ~erased_in;
    item_new.erased  = erased_in;
  end

  always_comb begin
    wr_ptr_d = push ? QPTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop  ? QPTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (pop && !push) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/elpd_back.sv -----
// Back part: check-row store, row-per-cycle peeling sequencer and output register.
`timescale 1ns / 1ps
`default_nettype none

module elpd_back import elpd_pkg::*; #(
  parameter int unsigned CODE_W = 12,
  parameter int unsigned ROWS   = 9
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [PASS_W-1:0] cfg_wdata_i,
  input  wire logic              item_valid_i,
  input  wire item_t             item_i,
  output      logic              item_pop_o,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic [FIELD_W-1:0] decoded_bits_o,
  output      logic [FIELD_W-1:0] erased_left_o,
  output      logic              success_o,
  output      logic [PASS_W-1:0] passes_used_o
);

  localparam int unsigned RowW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [RowW-1:0] LastRow = RowW'(ROWS - 1);

  back_state_e       state_q, state_d;
  logic [CODE_W-1:0] rows_q [ROWS];
  logic [PASS_W-1:0] max_passes_q;
  logic [RowW-1:0]   row_q;
  logic [PASS_W-1:0] passes_q;
  logic              progress_q;
  word_t             bits_q;
  word_t             erased_q;

  logic              out_valid_q;
  word_t             out_bits_q;
  word_t             out_erased_q;
  logic [PASS_W-1:0] out_passes_q;

  logic              start;
  logic              start_done;
  logic              row_we;
  logic              out_free;
  logic              out_load;
  word_t             row_cur;
  word_t             hit;
  logic              single;
  word_t             fill_bits;
  word_t             fill_erased;
  logic              last_row;
  logic              pass_progress;
  logic [PASS_W-1:0] passes_inc;
  logic              run_stop;

  assign out_free = !out_valid_q || !out_stall_i;

  // Peeling step on the current row: a row that covers exactly one erased bit fills it.
  always_comb begin
    row_cur       = FIELD_W'(rows_q[row_q]);
    hit           = row_cur & erased_q;
    single        = (hit != '0) && ((hit & (hit - 1'b1)) == '0);
    fill_erased   = single ? (erased_q & ~hit) : erased_q;
    fill_bits     = (single && (^(row_cur & bits_q))) ? (bits_q | hit) : bits_q;
    last_row      = (row_q == LastRow);
    pass_progress = progress_q || single;
    passes_inc    = PASS_W'(passes_q + 1'b1);
    run_stop      = last_row && ((fill_erased == '0) || (passes_inc >= max_passes_q) ||
                                 !pass_progress);
  end

  // A decode word with nothing erased or a zero pass limit skips the row sweep.
  assign start_done = (item_i.erased == '0) || (max_passes_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i && !item_i.is_load) begin
          state_d = start_done ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_stop) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    item_pop_o = (state_q == ST_IDLE) && item_valid_i;
    start      = item_pop_o && !item_i.is_load;
    row_we     = item_pop_o && item_i.is_load && item_i.load_ok;
    out_load   = (state_q == ST_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      max_passes_q <= MAX_PASSES_RESET;
      row_q        <= '0;
      passes_q     <= '0;
      progress_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      if (cfg_we_i) begin
        max_passes_q <= cfg_wdata_i;
      end
      if (start) begin
        row_q      <= '0;
        passes_q   <= '0;
        progress_q <= 1'b0;
      end else if (state_q == ST_RUN) begin
        if (last_row) begin
          row_q      <= '0;
          passes_q   <= passes_inc;
          progress_q <= 1'b0;
        end else begin
          row_q      <= RowW'(row_q + 1'b1);
          progress_q <= pass_progress;
        end
      end
    end
  end

  // The check-row store is cleared at reset; a load beyond the last row is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(ROWS); i++) begin
        rows_q[i] <= '0;
      end
    end else if (row_we) begin
      rows_q[item_i.index[RowW-1:0]] <= item_i.row[CODE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      bits_q   <= item_i.bits;
      erased_q <= item_i.erased;
    end else if (state_q == ST_RUN) begin
      bits_q   <= fill_bits;
      erased_q <= fill_erased;
    end
    if (out_load) begin
      out_bits_q   <= bits_q;
      out_erased_q <= erased_q;
      out_passes_q <= passes_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign decoded_bits_o = out_bits_q;
  assign erased_left_o  = out_erased_q;
  assign success_o      = (out_erased_q == '0);
  assign passes_used_o  = out_passes_q;

endmodule

`default_nettype wire

// ----- hdl/ldpc_erasure_peeling_decoder.sv -----
// Top level of the erasure peeling decoder: front queue plus peeling back end.
//
// Usage: input words arrive on in_valid_i / in_stall_o. A word with operation
// load writes one parity-check row and gives no result; a row index at or
// beyond the row count is dropped. A decode word gives exactly one result word
// on out_valid_o / out_stall_i. Words are handled strictly in order.
// The front holds a two-word queue, so input is taken while the back works.
// The back visits one check row per cycle. A decode sweeps all check rows
// once per pass, for the reported passes_used passes; with nothing erased or a
// zero pass limit it skips the sweep. A load leaves the back idle for the next word.
// max_passes is written through cfg_we_i / cfg_wdata_i while the block is idle.
// Reset clears the check-row store to zero, sets max_passes to 30 and empties
// the queue and output register. When the receiver stalls, the result holds
// in the output register; the back then waits and the queue fills up.
`timescale 1ns / 1ps
`default_nettype none

module ldpc_erasure_peeling_decoder import elpd_pkg::*; #(
  parameter int unsigned CODE_BITS  = 12,
  parameter int unsigned CHECK_ROWS = 9
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [PASS_W-1:0]      cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output      logic                   in_stall_o,
  input  wire logic                   operation_i,
  input  wire logic [ROW_INDEX_W-1:0] row_index_i,
  input  wire logic [FIELD_W-1:0]     row_bits_i,
  input  wire logic [FIELD_W-1:0]     hard_bits_i,
  input  wire logic [FIELD_W-1:0]     erasure_mask_i,
  output      logic                   out_valid_o,
  input  wire logic                   out_stall_i,
  output      logic [FIELD_W-1:0]     decoded_bits_o,
  output      logic [FIELD_W-1:0]     erased_left_o,
  output      logic                   success_o,
  output      logic [PASS_W-1:0]      passes_used_o
);

  // Only code bits that fit the fields and rows that a load can address matter.
  localparam int unsigned CodeW = (CODE_BITS < FIELD_W) ? CODE_BITS : FIELD_W;
  localparam int unsigned Rows  = (CHECK_ROWS < INDEX_ROWS) ? CHECK_ROWS : INDEX_ROWS;

  logic  item_valid;
  item_t item;
  logic  item_pop;

  elpd_front #(
    .CODE_W (CodeW),
    .ROWS   (Rows)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .row_index_i    (row_index_i),
    .row_bits_i     (row_bits_i),
    .hard_bits_i    (hard_bits_i),
    .erasure_mask_i (erasure_mask_i),
    .item_valid_o   (item_valid),
    .item_o         (item),
    .item_pop_i     (item_pop)
  );

  elpd_back #(
    .CODE_W (CodeW),
    .ROWS   (Rows)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .item_valid_i   (item_valid),
    .item_i         (item),
    .item_pop_o     (item_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .decoded_bits_o (decoded_bits_o),
    .erased_left_o  (erased_left_o),
    .success_o      (success_o),
    .passes_used_o  (passes_used_o)
  );

endmodule

`default_nettype wire

// ----- tb/ldpc_erasure_peeling_decoder_tb.sv -----
// Self-checking testbench for the LDPC erasure peeling decoder.
`timescale 1ns / 1ps

module ldpc_erasure_peeling_decoder_tb;
  import elpd_pkg::*;

  localparam int unsigned BITS       = 12;
  localparam int unsigned ROWS       = 9;
  localparam int unsigned SETTLE     = 16;
  localparam int unsigned LONG_HOLD  = 90;
  localparam int unsigned PHASE_N    = 7;
  localparam int unsigned PHASE_WORDS = 260;
  localparam int unsigned DIR_N      = 22;

  localparam logic [PASS_W-1:0] PHASE_LIMITS [PHASE_N] =
    '{6'd30, 6'd63, 6'd1, 6'd4, 6'd0, 6'd13, 6'd30};

  typedef struct packed {
    word_t             bits;
    word_t             erased;
    logic              ok;
    logic [PASS_W-1:0] passes;
  } peel_result_t;

  typedef struct packed {
    logic                   cfg_en;
    logic [PASS_W-1:0]      cfg_val;
    op_e                    op;
    logic [ROW_INDEX_W-1:0] idx;
    word_t                  row;
    word_t                  hard;
    word_t                  mask;
    logic                   typed;
    peel_result_t           res;
  } stim_row_t;

  localparam peel_result_t NO_RES = '{12'h000, 12'h000, 1'b0, 6'd0};

  // cfg, limit, op, index, row, hard, mask, typed, expected result
  localparam stim_row_t DIRECTED [DIR_N] = '{
    '{1'b0, 6'd0,  OP_DECODE, 4'd0,  12'h000, 12'hFFF, 12'h000, 1'b1,
      '{12'hFFF, 12'h000, 1'b1, 6'd0}},
    '{1'b0, 6'd0,  OP_DECODE, 4'd0,  12'h000, 12'hFFF, 12'h0F0, 1'b1,
      '{12'hF0F, 12'h0F0, 1'b0, 6'd1}},
    '{1'b0, 6'd0,  OP_LOAD,   4'd15, 12'hFFF, 12'h000, 12'h000, 1'b0, NO_RES},
    '{1'b0, 6'd0,  OP_LOAD,   4'd9,  12'hFFF, 12'h000, 12'h000, 1'b0, NO_RES},
    '{1'b0, 6'd0,  OP_DECODE, 4'd0,  12'h000, 12'h000, 12'h001, 1'b1,
      '{12'h000, 12'h001, 1'b0, 6'd1}},
    '{1'b0, 6'd0,  OP_LOAD,   4'd0,  12'h180, 12'h000, 12'h000, 1'b0, NO_RES},
    '{1'b0, 6'd0,  OP_LOAD,   4'd1,  12'h0C0, 12'h000, 12'h000, 1'b0, NO_RES},
    '{1'b0, 6'd0,  OP_LOAD,   4'd2,  12'h060, 12'h000, 12'h000, 1'b0, NO_RES},
    '{1'b0, 6'd0,  OP_LOAD,   4'd3,  12'h030, 12'h000, 12'h000, 1'b0, NO_RES},
    '{1'b0, 6'd0,  OP_LOAD,   4'd4,  12'h018, 12'h000, 12'h000, 1'b0, NO_RES},
    '{1'b0, 6'd0,  OP_LOAD,   4'd5,  12'h00C, 12'h000, 12'h000, 1'b0, NO_RES},
    '{1'b0, 6'd0,  OP_LOAD,   4'd6,  12'h006, 12'h000, 12'h000, 1'b0, NO_RES},
    '{1'b0, 6'd0,  OP_LOAD,   4'd7,  12'h003, 12'h000, 12'h000, 1'b0, NO_RES},
    '{1'b0, 6'd0,  OP_LOAD,   4'd8,  12'hFFF, 12'h000, 12'h000, 1'b0, NO_RES},
    '{1'b0, 6'd0,  OP_DECODE, 4'd0,  12'h000, 12'h001, 12'h1FE, 1'b0, NO_RES},
    '{1'b1, 6'd1,  OP_DECODE, 4'd0,  12'h000, 12'h001, 12'h1FE, 1'b0, NO_RES},
    '{1'b1, 6'd63, OP_DECODE, 4'd0,  12'h000, 12'hFFF, 12'hFFF, 1'b0, NO_RES},
    '{1'b1, 6'd0,  OP_DECODE, 4'd0,  12'h000, 12'hABC, 12'h0F0, 1'b1,
      '{12'hA0C, 12'h0F0, 1'b0, 6'd0}},
    '{1'b1, 6'd30, OP_DECODE, 4'd0,  12'h000, 12'h000, 12'h800, 1'b0, NO_RES},
    '{1'b0, 6'd0,  OP_LOAD,   4'd8,  12'h000, 12'h000, 12'h000, 1'b0, NO_RES},
    '{1'b0, 6'd0,  OP_DECODE, 4'd0,  12'h000, 12'h5A5, 12'h000, 1'b1,
      '{12'h5A5, 12'h000, 1'b1, 6'd0}},
    '{1'b0, 6'd0,  OP_DECODE, 4'd0,  12'h000, 12'hFFF, 12'hFFF, 1'b0, NO_RES}
  };

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   cfg_we_i       = 1'b0;
  logic [PASS_W-1:0]      cfg_wdata_i    = '0;
  logic                   in_valid_i     = 1'b0;
  logic                   in_stall_o;
  logic                   operation_i    = 1'b0;
  logic [ROW_INDEX_W-1:0] row_index_i    = '0;
  logic [FIELD_W-1:0]     row_bits_i     = '0;
  logic [FIELD_W-1:0]     hard_bits_i    = '0;
  logic [FIELD_W-1:0]     erasure_mask_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i    = 1'b0;
  logic [FIELD_W-1:0]     decoded_bits_o;
  logic [FIELD_W-1:0]     erased_left_o;
  logic                   success_o;
  logic [PASS_W-1:0]      passes_used_o;

  // Mirror of the block's check-row store and pass limit.
  word_t             row_store [ROWS] = '{default: '0};
  logic [PASS_W-1:0] pass_limit = MAX_PASSES_RESET;

  peel_result_t pending_results [$];
  int unsigned  mismatch_count = 0;
  logic         calm = 1'b0;
  logic         hold_req = 1'b0;

  ldpc_erasure_peeling_decoder #(
    .CODE_BITS  (BITS),
    .CHECK_ROWS (ROWS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .row_index_i    (row_index_i),
    .row_bits_i     (row_bits_i),
    .hard_bits_i    (hard_bits_i),
    .erasure_mask_i (erasure_mask_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .decoded_bits_o (decoded_bits_o),
    .erased_left_o  (erased_left_o),
    .success_o      (success_o),
    .passes_used_o  (passes_used_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #12_000_000;
    $display("[ldpc_erasure_peeling_decoder] ERROR");
    $finish;
  end

  // Peels the erased positions row by row, the way the block does it.
  function automatic peel_result_t peel(input word_t hard, input word_t mask);
    word_t             erased;
    word_t             bits;
    word_t             hit;
    logic [PASS_W-1:0] passes;
    logic              progress;
    peel_result_t      res;
    erased = mask;
    bits   = hard & ~mask;
    passes = '0;
    while (erased != '0 && passes < pass_limit) begin
      progress = 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        hit = row_store[r] & erased;
        if (hit != '0 && (hit & (hit - 1'b1)) == '0) begin
          erased &= ~hit;
          if (^(row_store[r] & bits)) bits |= hit;
          progress = 1'b1;
        end
      end
      passes++;
      if (!progress) break;
    end
    res.bits   = bits;
    res.erased = erased;
    res.ok     = (erased == '0);
    res.passes = passes;
    return res;
  endfunction

  function automatic word_t scatter(input int unsigned n);
    word_t w;
    w = '0;
    repeat (n) w[$urandom_range(0, BITS - 1)] = 1'b1;
    return w;
  endfunction

  // Offers one word, waits until it is taken, then updates the mirror.
  task automatic issue(input op_e op, input logic [ROW_INDEX_W-1:0] idx,
                       input word_t row, input word_t hard, input word_t mask,
                       input logic typed, input peel_result_t typed_res);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    row_index_i    <= idx;
    row_bits_i     <= row;
    hard_bits_i    <= hard;
    erasure_mask_i <= mask;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (op == OP_LOAD) begin
      if (idx < ROWS) row_store[idx] = row;
    end else begin
      pending_results.insert(pending_results.size(), typed ? typed_res : peel(hard, mask));
    end
  endtask

  // The limit may only change once the block has drained completely.
  task automatic set_pass_limit(input logic [PASS_W-1:0] limit);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    pass_limit = limit;
  endtask

  initial begin
    stim_row_t              s;
    int unsigned            counted;
    op_e                    op;
    logic [ROW_INDEX_W-1:0] idx;
    word_t                  row;
    word_t                  mask;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      s = DIRECTED[i];
      if (s.cfg_en) set_pass_limit(s.cfg_val);
      issue(s.op, s.idx, s.row, s.hard, s.mask, s.typed, s.res);
    end

    for (int p = 0; p < PHASE_N; p++) begin
      set_pass_limit(PHASE_LIMITS[p]);
      if (p == PHASE_N - 1) calm <= 1'b1;
      counted = 0;
      while (counted < PHASE_WORDS) begin
        if ($urandom_range(0, 3) == 0) begin
          op  = OP_LOAD;
          idx = ($urandom_range(0, 9) == 0) ? ROW_INDEX_W'($urandom_range(ROWS, 15))
                                             : ROW_INDEX_W'($urandom_range(0, ROWS - 1));
          case ($urandom_range(0, 7))
            0:       row = '0;
            1:       row = FIELD_W'($urandom_range(0, 4095));
            default: row = scatter($urandom_range(2, 4));
          endcase
          mask = '0;
        end else begin
          op  = OP_DECODE;
          idx = ROW_INDEX_W'($urandom_range(0, 15));
          row = FIELD_W'($urandom_range(0, 4095));
          case ($urandom_range(0, 9))
            0:       mask = '0;
            1:       mask = '1;
            2, 3:    mask = FIELD_W'($urandom_range(0, 4095));
            default: mask = scatter($urandom_range(1, 5));
          endcase
        end
        issue(op, idx, row, FIELD_W'($urandom_range(0, 4095)), mask, 1'b0, NO_RES);
        if (op == OP_DECODE || idx < ROWS) begin
          counted++;
          // The long receiver hold is requested exactly once.
          if (p == 1 && counted == 40) hold_req <= 1'b1;
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ldpc_erasure_peeling_decoder] OK");
    end else begin
      $display("[ldpc_erasure_peeling_decoder] ERROR");
    end
    $finish;
  end

  // Receiver side: short random stalls, plus one long hold that backs the block up.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req    <= 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && rst_ni && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    peel_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result word arrived with nothing expected");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (decoded_bits_o !== want.bits) begin
          $error("decoded_bits expected %h got %h", want.bits, decoded_bits_o);
          mismatch_count++;
        end
        if (erased_left_o !== want.erased) begin
          $error("erased_left expected %h got %h", want.erased, erased_left_o);
          mismatch_count++;
        end
        if (success_o !== want.ok) begin
          $error("success expected %b got %b", want.ok, success_o);
          mismatch_count++;
        end
        if (passes_used_o !== want.passes) begin
          $error("passes_used expected %0d got %0d", want.passes, passes_used_o);
          mismatch_count++;
        end
      end
    end
  end

endmodule
